[design/longest_repeating_subsequence_defines.svh]
// Assertion macros for the longest repeating subsequence block.
`ifndef LONGEST_REPEATING_SUBSEQUENCE_DEFINES_SVH
`define LONGEST_REPEATING_SUBSEQUENCE_DEFINES_SVH

`ifndef SYNTH
`define LRS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define LRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`define LRS_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("assertion failed");
`else
`define LRS_ASSERT_IMPL(lbl, ante, cons)
`define LRS_ASSERT_NEXT(lbl, ante, cons)
`define LRS_ASSERT_NEVER(lbl, cond)
`endif

`endif

[design/lrs_pkg.sv]
// Shared constants and the command type for the longest repeating subsequence block.
`default_nettype none

package lrs_pkg;

  localparam int unsigned MaxLenDefault = 64;
  localparam int unsigned CharW         = 8;
  localparam int unsigned LenW          = 6;
  localparam int unsigned OutTdataW     = 8;
  localparam logic [LenW-1:0] LenSat    = 6'd63;

  typedef struct packed {
    logic st_we;
    logic row_init;
    logic cap_ci;
    logic issue;
    logic first_row;
    logic out_load;
  } lrs_cmd_t;

endpackage

`default_nettype wire

[design/lrs_ram.sv]
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module lrs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[design/lrs_datapath.sv]
// Datapath: string store, DP row memory and the table cell update.
`default_nettype none

module lrs_datapath import lrs_pkg::*; #(
  parameter int unsigned MAX_LEN = MaxLenDefault
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire lrs_cmd_t                   cmd_i,
  input  wire logic [$clog2(MAX_LEN)-1:0] st_waddr_i,
  input  wire logic [CharW-1:0]           st_wdata_i,
  input  wire logic [$clog2(MAX_LEN)-1:0] st_raddr_i,
  input  wire logic [$clog2(MAX_LEN)-1:0] row_raddr_i,
  input  wire logic [$clog2(MAX_LEN)-1:0] row_idx_i,
  output logic      [LenW-1:0]            out_len_o
);

  localparam int unsigned AW = $clog2(MAX_LEN);

  logic [CharW-1:0] st_rdata;
  logic [LenW-1:0]  row_rdata;
  logic             proc_q;
  logic [AW-1:0]    pcol_q;
  logic [CharW-1:0] ci_q;
  logic [LenW-1:0]  left_q, diag_q, out_len_q;
  logic [LenW-1:0]  up, inc, best, val;
  logic             match;

  lrs_ram #(.Width(CharW), .Depth(MAX_LEN)) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.st_we),
    .waddr_i(st_waddr_i),
    .wdata_i(st_wdata_i),
    .raddr_i(st_raddr_i),
    .rdata_o(st_rdata)
  );

  lrs_ram #(.Width(LenW), .Depth(MAX_LEN)) u_row (
    .clk_i  (clk_i),
    .we_i   (proc_q),
    .waddr_i(pcol_q),
    .wdata_i(val),
    .raddr_i(row_raddr_i),
    .rdata_o(row_rdata)
  );

  // first row reads as the all-zero initial row
  assign up    = cmd_i.first_row ? '0 : row_rdata;
  assign match = (row_idx_i != pcol_q) && (ci_q == st_rdata);
  assign inc   = (diag_q == LenSat) ? diag_q : diag_q + 1'b1;
  assign best  = (up > left_q) ? up : left_q;
  assign val   = match ? inc : best;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proc_q <= 1'b0;
    end else begin
      proc_q <= cmd_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    pcol_q <= row_raddr_i;
    if (cmd_i.cap_ci) begin
      ci_q <= st_rdata;
    end
    if (cmd_i.row_init) begin
      left_q <= '0;
      diag_q <= '0;
    end else if (proc_q) begin
      left_q <= val;
      diag_q <= up;
    end
    if (cmd_i.out_load) begin
      out_len_q <= left_q;
    end
  end

  assign out_len_o = out_len_q;

endmodule

`default_nettype wire

[design/lrs_ctrl.sv]
// Controller: load counter, row/column sequencer and output handshake.
`default_nettype none

module lrs_ctrl import lrs_pkg::*; #(
  parameter int unsigned MAX_LEN = MaxLenDefault
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire logic                       in_has_char_i,
  input  wire logic                       in_last_i,
  output logic                            in_ready_o,
  input  wire logic                       out_ready_i,
  output logic                            out_valid_o,
  output logic                            out_ovf_o,
  output lrs_cmd_t                        cmd_o,
  output logic      [$clog2(MAX_LEN)-1:0] st_waddr_o,
  output logic      [$clog2(MAX_LEN)-1:0] st_raddr_o,
  output logic      [$clog2(MAX_LEN)-1:0] row_raddr_o,
  output logic      [$clog2(MAX_LEN)-1:0] row_idx_o
);

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned CW = $clog2(MAX_LEN + 1);

  typedef enum logic [2:0] {
    S_LOAD, S_START, S_ROW, S_CI, S_CELL, S_TAIL, S_DONE
  } state_e;

  state_e        state_q;
  logic [CW-1:0] cnt_q, cnt_m1;
  logic          ovf_q, out_vld_q, out_ovf_q;
  logic [AW-1:0] i_q, j_q, last_idx;
  logic          accept, full;

  assign cnt_m1   = cnt_q - 1'b1;
  assign last_idx = cnt_m1[AW-1:0];
  assign full     = (cnt_q == CW'(MAX_LEN));
  assign accept   = in_valid_i && (state_q == S_LOAD);

  always_comb begin
    cmd_o           = '0;
    cmd_o.st_we     = accept && in_has_char_i && !full;
    cmd_o.row_init  = (state_q inside {S_START, S_ROW});
    cmd_o.cap_ci    = (state_q == S_CI);
    cmd_o.issue     = (state_q inside {S_CI, S_CELL});
    cmd_o.first_row = (i_q == '0);
    cmd_o.out_load  = (state_q == S_DONE) && (!out_vld_q || out_ready_i);
  end

  assign in_ready_o  = (state_q == S_LOAD);
  assign st_waddr_o  = cnt_q[AW-1:0];
  assign st_raddr_o  = (state_q == S_ROW) ? i_q : j_q;
  assign row_raddr_o = j_q;
  assign row_idx_o   = i_q;
  assign out_valid_o = out_vld_q;
  assign out_ovf_o   = out_ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      i_q       <= '0;
      j_q       <= '0;
      out_vld_q <= 1'b0;
      out_ovf_q <= 1'b0;
    end else begin
      if (out_vld_q && out_ready_i && !cmd_o.out_load) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_LOAD: begin
          if (accept) begin
            if (in_has_char_i) begin
              if (!full) begin
                cnt_q <= cnt_q + 1'b1;
              end else begin
                ovf_q <= 1'b1;
              end
            end
            if (in_last_i) begin
              state_q <= S_START;
            end
          end
        end
        S_START: begin
          i_q <= '0;
          state_q <= (cnt_q == '0) ? S_DONE : S_ROW;
        end
        S_ROW: begin
          j_q     <= '0;
          state_q <= S_CI;
        end
        S_CI: begin
          j_q     <= j_q + 1'b1;
          state_q <= (last_idx == '0) ? S_TAIL : S_CELL;
        end
        S_CELL: begin
          if (j_q == last_idx) begin
            state_q <= S_TAIL;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        S_TAIL: begin
          if (i_q == last_idx) begin
            state_q <= S_DONE;
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= S_ROW;
          end
        end
        S_DONE: begin
          if (cmd_o.out_load) begin
            out_vld_q <= 1'b1;
            out_ovf_q <= ovf_q;
            cnt_q     <= '0;
            ovf_q     <= 1'b0;
            state_q   <= S_LOAD;
          end
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[design/longest_repeating_subsequence.sv]
// Top level of the longest repeating subsequence block.
// Usage:
//   Input stream: one item per character, tdata = byte, tuser = has_char,
//   tlast ends the string. Items without a character and without tlast
//   do nothing. Characters past MAX_LEN are dropped and flagged.
//   Output stream: one item per string, tdata = repeat length,
//   tuser = overflow flag.
//   Each DP row starts with one store read for the row character, then
//   processes one cell per cycle through the simple dual-port row memory.
//   Input is accepted one item per cycle while loading and not at all
//   during the computation.
//   Reset empties the string and clears any pending result.
//   A stalled receiver holds the result in the output register; the next
//   string may load meanwhile, and its result waits until the register
//   is free.
`default_nettype none
`include "longest_repeating_subsequence_defines.svh"

module longest_repeating_subsequence import lrs_pkg::*; #(
  parameter int unsigned MAX_LEN = MaxLenDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [CharW-1:0]     s_axis_tdata,   // [7:0] char_code
  input  wire logic                 s_axis_tuser,   // [0] has_char
  input  wire logic                 s_axis_tlast,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic      [OutTdataW-1:0] m_axis_tdata,   // [5:0] repeat_length, rest zero
  output logic                      m_axis_tuser    // [0] overflowed
);

  localparam int unsigned AW = $clog2(MAX_LEN);

  lrs_cmd_t      cmd;
  logic [AW-1:0] st_waddr, st_raddr, row_raddr, row_idx;
  logic [LenW-1:0] out_len;

  lrs_ctrl #(.MAX_LEN(MAX_LEN)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_has_char_i(s_axis_tuser),
    .in_last_i    (s_axis_tlast),
    .in_ready_o   (s_axis_tready),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_ovf_o    (m_axis_tuser),
    .cmd_o        (cmd),
    .st_waddr_o   (st_waddr),
    .st_raddr_o   (st_raddr),
    .row_raddr_o  (row_raddr),
    .row_idx_o    (row_idx)
  );

  lrs_datapath #(.MAX_LEN(MAX_LEN)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .st_waddr_i (st_waddr),
    .st_wdata_i (s_axis_tdata),
    .st_raddr_i (st_raddr),
    .row_raddr_i(row_raddr),
    .row_idx_i  (row_idx),
    .out_len_o  (out_len)
  );

  assign m_axis_tdata = OutTdataW'(out_len);

  `LRS_ASSERT_NEVER(a_no_issue_while_loading, cmd.issue && s_axis_tready)
  `LRS_ASSERT_IMPL(a_store_only_on_item, cmd.st_we, s_axis_tvalid && s_axis_tready && s_axis_tuser)
  `LRS_ASSERT_NEXT(a_load_shows_result, cmd.out_load, m_axis_tvalid)
  `LRS_ASSERT_IMPL(a_valid_rises_from_load, $rose(m_axis_tvalid), $past(cmd.out_load))

endmodule

`default_nettype wire
